// ===== hw/rtl/rotate_and_isometric_project_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ROTATE_AND_ISOMETRIC_PROJECT_CORE_MACROS_SVH
`define ROTATE_AND_ISOMETRIC_PROJECT_CORE_MACROS_SVH

// property checked outside reset
`define RISO_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define RISO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/riso_pkg.sv =====
// ----------------------------------------------------------------------------
// riso_pkg
// Widths, register map, coefficient bundle and fixed point helpers shared by
// the vertex transform core.
// ----------------------------------------------------------------------------
package riso_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int TRIG_FRACTION = 14;
   localparam int TRIG_WIDTH    = TRIG_FRACTION + 2;
   localparam int INNER_WIDTH   = COORD_WIDTH + 2;
   localparam int OUT_WIDTH     = INNER_WIDTH;
   localparam int PROD_WIDTH    = INNER_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int RND_WIDTH     = SUM_WIDTH - TRIG_FRACTION + 1;
   localparam int WIDE_WIDTH    = RND_WIDTH + 1;

   localparam int IN_DATA_WIDTH  = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_WIDTH = ((2 * OUT_WIDTH + 7) / 8) * 8;

   localparam int NUM_REGS       = 8;
   localparam int REG_IDX_WIDTH  = $clog2(NUM_REGS);
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = REG_IDX_WIDTH + 2;

   localparam logic [REG_IDX_WIDTH-1:0] REG_COS_X    = REG_IDX_WIDTH'(0);
   localparam logic [REG_IDX_WIDTH-1:0] REG_SIN_X    = REG_IDX_WIDTH'(1);
   localparam logic [REG_IDX_WIDTH-1:0] REG_COS_Y    = REG_IDX_WIDTH'(2);
   localparam logic [REG_IDX_WIDTH-1:0] REG_SIN_Y    = REG_IDX_WIDTH'(3);
   localparam logic [REG_IDX_WIDTH-1:0] REG_COS_Z    = REG_IDX_WIDTH'(4);
   localparam logic [REG_IDX_WIDTH-1:0] REG_SIN_Z    = REG_IDX_WIDTH'(5);
   localparam logic [REG_IDX_WIDTH-1:0] REG_PROJ_COS = REG_IDX_WIDTH'(6);
   localparam logic [REG_IDX_WIDTH-1:0] REG_PROJ_SIN = REG_IDX_WIDTH'(7);

   // unity and thirty degrees in Q1.TRIG_FRACTION
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE  = TRIG_WIDTH'(1 << TRIG_FRACTION);
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ZERO = '0;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_COS30 =
      TRIG_WIDTH'((14189 * (1 << TRIG_FRACTION)) / 16384);
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_SIN30 = TRIG_WIDTH'(1 << (TRIG_FRACTION - 1));

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] cos_x;
      logic signed [TRIG_WIDTH-1:0] sin_x;
      logic signed [TRIG_WIDTH-1:0] cos_y;
      logic signed [TRIG_WIDTH-1:0] sin_y;
      logic signed [TRIG_WIDTH-1:0] cos_z;
      logic signed [TRIG_WIDTH-1:0] sin_z;
      logic signed [TRIG_WIDTH-1:0] proj_cos;
      logic signed [TRIG_WIDTH-1:0] proj_sin;
   } coef_type;

   // floor(v / 2^F) plus the half bit: round to nearest, ties up
   function automatic logic signed [RND_WIDTH-1:0] round_frac(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [RND_WIDTH-1:0] fl;
      logic        [RND_WIDTH-1:0] half;
      fl   = {v[SUM_WIDTH-1], v[SUM_WIDTH-1:TRIG_FRACTION]};
      half = {{(RND_WIDTH-1){1'b0}}, v[TRIG_FRACTION-1]};
      return fl + signed'(half);
   endfunction

   // clamp to INNER_WIDTH signed bits
   function automatic logic signed [INNER_WIDTH-1:0] sat_inner(
      input logic signed [WIDE_WIDTH-1:0] v);
      logic fits;
      fits = (v[WIDE_WIDTH-1:INNER_WIDTH-1] == '0) ||
             (v[WIDE_WIDTH-1:INNER_WIDTH-1] == '1);
      if (fits) begin
         return v[INNER_WIDTH-1:0];
      end else if (v[WIDE_WIDTH-1]) begin
         return {1'b1, {(INNER_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(INNER_WIDTH-1){1'b1}}};
      end
   endfunction

endpackage

// ===== hw/rtl/rotate_and_isometric_project_core.sv =====
// ----------------------------------------------------------------------------
// rotate_and_isometric_project_core
// Vertex transform: rotation about X, Y and Z, then isometric projection.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages from a req transfer to rsp_tvalid, two per
//   rotation and three for the projection, the last one being the output
//   register; the transfer edge loads the first stage.
// Throughput: one point per cycle; every stage holds one item and stalls only
//   when the stage after it is full and not draining.
// Reset: clears all stage valid bits and loads the coefficient registers with
//   identity rotations and a thirty degree projection.
module rotate_and_isometric_project_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input points
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [riso_pkg::IN_DATA_WIDTH-1:0]     req_tdata,   // in_x, in_y, in_z
   // screen points
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [riso_pkg::OUT_DATA_WIDTH-1:0]    rsp_tdata,   // screen_x, screen_y, zero pad
   // configuration
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [riso_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [riso_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [riso_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW = riso_pkg::COORD_WIDTH;
   localparam int IW = riso_pkg::INNER_WIDTH;
   localparam int OW = riso_pkg::OUT_WIDTH;

   riso_pkg::coef_type    coef;
   logic signed [CW-1:0]  in_x, in_y, in_z;
   logic signed [IW-1:0]  rx_y, rx_z, rx_x;
   logic signed [IW-1:0]  ry_z, ry_x, ry_y;
   logic signed [IW-1:0]  rz_x, rz_y, rz_z;
   logic signed [OW-1:0]  screen_x, screen_y;
   logic                  rx_valid, rx_ready;
   logic                  ry_valid, ry_ready;
   logic                  rz_valid, rz_ready;

   assign in_x = req_tdata[CW-1:0];
   assign in_y = req_tdata[2*CW-1:CW];
   assign in_z = req_tdata[3*CW-1:2*CW];

   riso_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // about X: pair (y, z)
   riso_rotate u_rot_x (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_a     (IW'(in_y)),
      .up_b     (IW'(in_z)),
      .up_p     (IW'(in_x)),
      .coef_cos (coef.cos_x),
      .coef_sin (coef.sin_x),
      .dn_valid (rx_valid),
      .dn_ready (rx_ready),
      .dn_a     (rx_y),
      .dn_b     (rx_z),
      .dn_p     (rx_x)
   );

   // about Y: pair (z, x)
   riso_rotate u_rot_y (
      .clock    (clock),
      .reset    (reset),
      .up_valid (rx_valid),
      .up_ready (rx_ready),
      .up_a     (rx_z),
      .up_b     (rx_x),
      .up_p     (rx_y),
      .coef_cos (coef.cos_y),
      .coef_sin (coef.sin_y),
      .dn_valid (ry_valid),
      .dn_ready (ry_ready),
      .dn_a     (ry_z),
      .dn_b     (ry_x),
      .dn_p     (ry_y)
   );

   // about Z: pair (x, y)
   riso_rotate u_rot_z (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ry_valid),
      .up_ready (ry_ready),
      .up_a     (ry_x),
      .up_b     (ry_y),
      .up_p     (ry_z),
      .coef_cos (coef.cos_z),
      .coef_sin (coef.sin_z),
      .dn_valid (rz_valid),
      .dn_ready (rz_ready),
      .dn_a     (rz_x),
      .dn_b     (rz_y),
      .dn_p     (rz_z)
   );

   riso_project u_proj (
      .clock    (clock),
      .reset    (reset),
      .up_valid (rz_valid),
      .up_ready (rz_ready),
      .up_x     (rz_x),
      .up_y     (rz_y),
      .up_z     (rz_z),
      .proj_cos (coef.proj_cos),
      .proj_sin (coef.proj_sin),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_sx    (screen_x),
      .dn_sy    (screen_y)
   );

   assign rsp_tdata = riso_pkg::OUT_DATA_WIDTH'({screen_y, screen_x});

endmodule

// ===== hw/rtl/riso_csr.sv =====
// ----------------------------------------------------------------------------
// riso_csr
// Coefficient register file behind an APB-style slave port.
// ----------------------------------------------------------------------------
module riso_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [riso_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [riso_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [riso_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output riso_pkg::coef_type                   coef
);

   riso_pkg::coef_type                       coef_ff;
   logic [riso_pkg::REG_IDX_WIDTH-1:0]       idx;
   logic                                     wr_en;
   logic signed [riso_pkg::TRIG_WIDTH-1:0]   wdata;
   logic signed [riso_pkg::TRIG_WIDTH-1:0]   rdata;

   assign csr_pready = 1'b1;
   assign idx   = csr_paddr[riso_pkg::CSR_ADDR_WIDTH-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata = csr_pwdata[riso_pkg::TRIG_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.cos_x    <= riso_pkg::TRIG_ONE;
         coef_ff.sin_x    <= riso_pkg::TRIG_ZERO;
         coef_ff.cos_y    <= riso_pkg::TRIG_ONE;
         coef_ff.sin_y    <= riso_pkg::TRIG_ZERO;
         coef_ff.cos_z    <= riso_pkg::TRIG_ONE;
         coef_ff.sin_z    <= riso_pkg::TRIG_ZERO;
         coef_ff.proj_cos <= riso_pkg::TRIG_COS30;
         coef_ff.proj_sin <= riso_pkg::TRIG_SIN30;
      end else if (wr_en) begin
         case (idx)
            riso_pkg::REG_COS_X:    coef_ff.cos_x    <= wdata;
            riso_pkg::REG_SIN_X:    coef_ff.sin_x    <= wdata;
            riso_pkg::REG_COS_Y:    coef_ff.cos_y    <= wdata;
            riso_pkg::REG_SIN_Y:    coef_ff.sin_y    <= wdata;
            riso_pkg::REG_COS_Z:    coef_ff.cos_z    <= wdata;
            riso_pkg::REG_SIN_Z:    coef_ff.sin_z    <= wdata;
            riso_pkg::REG_PROJ_COS: coef_ff.proj_cos <= wdata;
            riso_pkg::REG_PROJ_SIN: coef_ff.proj_sin <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         riso_pkg::REG_COS_X:    rdata = coef_ff.cos_x;
         riso_pkg::REG_SIN_X:    rdata = coef_ff.sin_x;
         riso_pkg::REG_COS_Y:    rdata = coef_ff.cos_y;
         riso_pkg::REG_SIN_Y:    rdata = coef_ff.sin_y;
         riso_pkg::REG_COS_Z:    rdata = coef_ff.cos_z;
         riso_pkg::REG_SIN_Z:    rdata = coef_ff.sin_z;
         riso_pkg::REG_PROJ_COS: rdata = coef_ff.proj_cos;
         riso_pkg::REG_PROJ_SIN: rdata = coef_ff.proj_sin;
         default:                rdata = riso_pkg::TRIG_ZERO;
      endcase
   end

   assign csr_prdata = riso_pkg::CSR_DATA_WIDTH'(rdata);
   assign coef       = coef_ff;

endmodule

// ===== hw/rtl/riso_rotate.sv =====
// ----------------------------------------------------------------------------
// riso_rotate
// Plane rotation of one coordinate pair, two register stages:
//   a' = a*cos - b*sin, b' = a*sin + b*cos; the third coordinate rides along.
// ----------------------------------------------------------------------------
module riso_rotate (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    up_valid,
   output logic                                    up_ready,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_a,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_b,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_p,
   input  logic signed [riso_pkg::TRIG_WIDTH-1:0]  coef_cos,
   input  logic signed [riso_pkg::TRIG_WIDTH-1:0]  coef_sin,
   output logic                                    dn_valid,
   input  logic                                    dn_ready,
   output logic signed [riso_pkg::INNER_WIDTH-1:0] dn_a,
   output logic signed [riso_pkg::INNER_WIDTH-1:0] dn_b,
   output logic signed [riso_pkg::INNER_WIDTH-1:0] dn_p
);

   localparam int PW = riso_pkg::PROD_WIDTH;
   localparam int SW = riso_pkg::SUM_WIDTH;
   localparam int WW = riso_pkg::WIDE_WIDTH;

   // stage 1: products
   logic                                     s1_vld_ff;
   logic signed [PW-1:0]                     s1_ac_ff, s1_bs_ff, s1_as_ff, s1_bc_ff;
   logic signed [PW-1:0]                     s1_ac_in, s1_bs_in, s1_as_in, s1_bc_in;
   logic signed [riso_pkg::INNER_WIDTH-1:0]  s1_p_ff;
   // stage 2: sums, rounded and clamped
   logic                                     s2_vld_ff;
   logic signed [riso_pkg::INNER_WIDTH-1:0]  s2_a_ff, s2_b_ff, s2_p_ff;
   logic signed [riso_pkg::INNER_WIDTH-1:0]  s2_a_in, s2_b_in;
   logic                                     s1_load, s2_load;

   assign s2_load  = !s2_vld_ff || dn_ready;
   assign s1_load  = !s1_vld_ff || s2_load;
   assign up_ready = s1_load;

   always_comb begin
      s1_ac_in = PW'(up_a) * PW'(coef_cos);
      s1_bs_in = PW'(up_b) * PW'(coef_sin);
      s1_as_in = PW'(up_a) * PW'(coef_sin);
      s1_bc_in = PW'(up_b) * PW'(coef_cos);
      s2_a_in  = riso_pkg::sat_inner(WW'(riso_pkg::round_frac(SW'(s1_ac_ff) - SW'(s1_bs_ff))));
      s2_b_in  = riso_pkg::sat_inner(WW'(riso_pkg::round_frac(SW'(s1_as_ff) + SW'(s1_bc_ff))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_vld_ff <= up_valid;
         end
         if (s2_load) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && up_valid) begin
         s1_ac_ff <= s1_ac_in;
         s1_bs_ff <= s1_bs_in;
         s1_as_ff <= s1_as_in;
         s1_bc_ff <= s1_bc_in;
         s1_p_ff  <= up_p;
      end
      if (s2_load && s1_vld_ff) begin
         s2_a_ff <= s2_a_in;
         s2_b_ff <= s2_b_in;
         s2_p_ff <= s1_p_ff;
      end
   end

   assign dn_valid = s2_vld_ff;
   assign dn_a     = s2_a_ff;
   assign dn_b     = s2_b_ff;
   assign dn_p     = s2_p_ff;

endmodule

// ===== hw/rtl/riso_project.sv =====
// ----------------------------------------------------------------------------
// riso_project
// Isometric projection, three register stages: difference and sum, products,
// then rounding, height subtract and output clamp.
// ----------------------------------------------------------------------------
module riso_project (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    up_valid,
   output logic                                    up_ready,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_x,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_y,
   input  logic signed [riso_pkg::INNER_WIDTH-1:0] up_z,
   input  logic signed [riso_pkg::TRIG_WIDTH-1:0]  proj_cos,
   input  logic signed [riso_pkg::TRIG_WIDTH-1:0]  proj_sin,
   output logic                                    dn_valid,
   input  logic                                    dn_ready,
   output logic signed [riso_pkg::OUT_WIDTH-1:0]   dn_sx,
   output logic signed [riso_pkg::OUT_WIDTH-1:0]   dn_sy
);

   localparam int IW = riso_pkg::INNER_WIDTH;
   localparam int PW = riso_pkg::PROD_WIDTH;
   localparam int SW = riso_pkg::SUM_WIDTH;
   localparam int WW = riso_pkg::WIDE_WIDTH;

   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                  s1_load, s2_load, s3_load;
   logic signed [IW-1:0]  s1_dif_ff, s1_sum_ff, s1_z_ff;
   logic signed [IW-1:0]  s1_dif_in, s1_sum_in;
   logic signed [PW-1:0]  s2_pc_ff, s2_ps_ff;
   logic signed [PW-1:0]  s2_pc_in, s2_ps_in;
   logic signed [IW-1:0]  s2_z_ff;
   logic signed [IW-1:0]  s3_sx_ff, s3_sy_ff;
   logic signed [IW-1:0]  s3_sx_in, s3_sy_in;

   assign s3_load  = !s3_vld_ff || dn_ready;
   assign s2_load  = !s2_vld_ff || s3_load;
   assign s1_load  = !s1_vld_ff || s2_load;
   assign up_ready = s1_load;

   always_comb begin
      s1_dif_in = riso_pkg::sat_inner(WW'(up_x) - WW'(up_y));
      s1_sum_in = riso_pkg::sat_inner(WW'(up_x) + WW'(up_y));
      s2_pc_in  = PW'(s1_dif_ff) * PW'(proj_cos);
      s2_ps_in  = PW'(s1_sum_ff) * PW'(proj_sin);
      s3_sx_in  = riso_pkg::sat_inner(WW'(riso_pkg::round_frac(SW'(s2_pc_ff))));
      s3_sy_in  = riso_pkg::sat_inner(WW'(riso_pkg::round_frac(SW'(s2_ps_ff))) - WW'(s2_z_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_vld_ff <= up_valid;
         end
         if (s2_load) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_load) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && up_valid) begin
         s1_dif_ff <= s1_dif_in;
         s1_sum_ff <= s1_sum_in;
         s1_z_ff   <= up_z;
      end
      if (s2_load && s1_vld_ff) begin
         s2_pc_ff <= s2_pc_in;
         s2_ps_ff <= s2_ps_in;
         s2_z_ff  <= s1_z_ff;
      end
      if (s3_load && s2_vld_ff) begin
         s3_sx_ff <= s3_sx_in;
         s3_sy_ff <= s3_sy_in;
      end
   end

   assign dn_valid = s3_vld_ff;
   assign dn_sx    = s3_sx_ff;
   assign dn_sy    = s3_sy_ff;

endmodule

// ===== hw/rtl/riso_checker.sv =====
// ----------------------------------------------------------------------------
// riso_checker
// Port-level checks for the vertex transform core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotate_and_isometric_project_core_macros.svh"

module riso_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [riso_pkg::OUT_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                csr_pready
);

   // a result held back by the sink keeps its data
   `RISO_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp data changed while stalled")
   // nothing comes out right after reset
   `RISO_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid set after reset")
   // an empty output stage means the whole pipe can take a point
   `RISO_ASSERT_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "input stalled with empty output")
   // padding above the two fields stays zero
   `RISO_ASSERT_RST(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[riso_pkg::OUT_DATA_WIDTH-1:2*riso_pkg::OUT_WIDTH] == '0, "rsp padding not zero")

endmodule

bind rotate_and_isometric_project_core riso_checker u_riso_checker (.*);
